// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition pre implies condition post in the same cycle.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition pre implies condition post in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/scwf_pkg.sv -----
// Types, codes and constants of the comment and whitespace filter.
`timescale 1ns / 1ps
`default_nettype none

package scwf_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // input commands
    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_EOL  = 2'd1;
    localparam logic [1:0] CMD_EOI  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_STRING = 2'd1;
    localparam logic [1:0] ERR_BLOCK  = 2'd2;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EOL   = 2'd1,
        KIND_EOI   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_LINE   = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic [1:0]  err;
        logic        last;
    } result_t;

    // all results caused by one input word
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        result_t [MAX_RESULTS-1:0]    res;
    } bundle_t;

    function automatic result_t mk_res(kind_t k, logic [7:0] c, logic [1:0] e);
        result_t r;
        r.kind = k;
        r.ch   = c;
        r.err  = e;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scwf_lexer.sv -----
// Lexer state and combinational result generation for one input word.
`timescale 1ns / 1ps
`default_nettype none

module scwf_lexer
    import scwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       go,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] ch,
    output bundle_t         bundle
);

    mode_t mode_reg, mode_next;
    logic  als_reg, als_next;     // at line start
    logic  skb_reg, skb_next;     // skip blanks
    logic  hsp_reg, hsp_next;     // held space
    logic  hsl_reg, hsl_next;     // held slash
    logic  hst_reg, hst_next;     // held star
    logic  lho_reg, lho_next;     // line has output
    logic  stop_reg, stop_next;   // stopped on error

    logic                  blank;
    logic                  done;
    logic [RES_CNT_W-1:0]  n;
    logic [RES_CNT_W-1:0]  n_m1;
    result_t [MAX_RESULTS-1:0] res;

    always_comb
    begin
        mode_next = mode_reg;
        als_next  = als_reg;
        skb_next  = skb_reg;
        hsp_next  = hsp_reg;
        hsl_next  = hsl_reg;
        hst_next  = hst_reg;
        lho_next  = lho_reg;
        stop_next = stop_reg;
        n         = '0;
        res       = '0;
        done      = 1'b0;
        blank     = (ch == CH_SPACE) || (ch == CH_TAB);

        if (!stop_reg)
        begin
            if (cmd == CMD_CHAR)
            begin
                case (mode_reg)
                    MODE_NORMAL:
                    begin
                        if (hsl_reg)
                        begin
                            hsl_next = 1'b0;
                            if (ch == CH_SLASH)
                            begin
                                mode_next = MODE_LINE;
                                hsp_next  = 1'b0;
                                done      = 1'b1;
                            end
                            else if (ch == CH_STAR)
                            begin
                                mode_next = MODE_BLOCK;
                                hst_next  = 1'b0;
                                done      = 1'b1;
                            end
                            else
                            begin
                                if (hsp_next)
                                begin
                                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_SPACE, ERR_NONE);
                                    n        = n + RES_CNT_W'(1);
                                    hsp_next = 1'b0;
                                end
                                res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_SLASH, ERR_NONE);
                                n        = n + RES_CNT_W'(1);
                                lho_next = 1'b1;
                                skb_next = 1'b0;
                            end
                        end
                        if (!done)
                        begin
                            if (blank)
                            begin
                                if (!als_next && !skb_next)
                                begin
                                    hsp_next = 1'b1;
                                    skb_next = 1'b1;
                                end
                            end
                            else
                            begin
                                als_next = 1'b0;
                                if (ch == CH_SLASH)
                                begin
                                    hsl_next = 1'b1;
                                end
                                else
                                begin
                                    if (hsp_next)
                                    begin
                                        res[n[RES_IDX_W-1:0]] =
                                            mk_res(KIND_CHAR, CH_SPACE, ERR_NONE);
                                        n        = n + RES_CNT_W'(1);
                                        hsp_next = 1'b0;
                                    end
                                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, ch, ERR_NONE);
                                    n        = n + RES_CNT_W'(1);
                                    lho_next = 1'b1;
                                    skb_next = 1'b0;
                                    if (ch == CH_QUOTE)
                                    begin
                                        mode_next = MODE_STRING;
                                    end
                                end
                            end
                        end
                    end
                    MODE_STRING:
                    begin
                        als_next = 1'b0;
                        if (hsp_next)
                        begin
                            res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_SPACE, ERR_NONE);
                            n        = n + RES_CNT_W'(1);
                            hsp_next = 1'b0;
                        end
                        res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, ch, ERR_NONE);
                        n        = n + RES_CNT_W'(1);
                        lho_next = 1'b1;
                        if (ch == CH_QUOTE)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (!blank)
                        begin
                            als_next = 1'b0;
                        end
                        if (hst_reg && ch == CH_SLASH)
                        begin
                            mode_next = MODE_NORMAL;
                            hst_next  = 1'b0;
                        end
                        else
                        begin
                            hst_next = (ch == CH_STAR);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd == CMD_EOL || cmd == CMD_EOI)
            begin
                // close the line: flush a trailing slash, drop a trailing blank, emit EOL/EOI or an error
                if (mode_reg == MODE_NORMAL && hsl_reg)
                begin
                    if (hsp_reg)
                    begin
                        res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_SPACE, ERR_NONE);
                        n = n + RES_CNT_W'(1);
                    end
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_CHAR, CH_SLASH, ERR_NONE);
                    n        = n + RES_CNT_W'(1);
                    lho_next = 1'b1;
                end
                if (mode_reg == MODE_STRING)
                begin
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_ERROR, 8'd0, ERR_STRING);
                    n         = n + RES_CNT_W'(1);
                    stop_next = 1'b1;
                end
                else if (lho_next)
                begin
                    if (mode_reg == MODE_BLOCK)
                    begin
                        res[n[RES_IDX_W-1:0]] = mk_res(KIND_ERROR, 8'd0, ERR_BLOCK);
                        n         = n + RES_CNT_W'(1);
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        res[n[RES_IDX_W-1:0]] = mk_res(KIND_EOL, 8'd0, ERR_NONE);
                        n = n + RES_CNT_W'(1);
                    end
                end
                if (mode_reg == MODE_LINE)
                begin
                    mode_next = MODE_NORMAL;
                end
                als_next = 1'b1;
                skb_next = 1'b0;
                hsp_next = 1'b0;
                hsl_next = 1'b0;
                hst_next = 1'b0;
                lho_next = 1'b0;

                if (cmd == CMD_EOI && !stop_next)
                begin
                    if (mode_next == MODE_BLOCK)
                    begin
                        res[n[RES_IDX_W-1:0]] = mk_res(KIND_ERROR, 8'd0, ERR_BLOCK);
                        n         = n + RES_CNT_W'(1);
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        res[n[RES_IDX_W-1:0]] = mk_res(KIND_EOI, 8'd0, ERR_NONE);
                        n         = n + RES_CNT_W'(1);
                        mode_next = MODE_NORMAL;
                    end
                end
            end
        end

        n_m1 = n - RES_CNT_W'(1);
        if (n != '0)
        begin
            res[n_m1[RES_IDX_W-1:0]].last = 1'b1;
        end
        bundle.count = n;
        bundle.res   = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            als_reg  <= 1'b1;
            skb_reg  <= 1'b0;
            hsp_reg  <= 1'b0;
            hsl_reg  <= 1'b0;
            hst_reg  <= 1'b0;
            lho_reg  <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (go)
        begin
            mode_reg <= mode_next;
            als_reg  <= als_next;
            skb_reg  <= skb_next;
            hsp_reg  <= hsp_next;
            hsl_reg  <= hsl_next;
            hst_reg  <= hst_next;
            lho_reg  <= lho_next;
            stop_reg <= stop_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/scwf_out_queue.sv -----
// Two-entry queue of result bundles, unpacked one word per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module scwf_out_queue
    import scwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  bundle_t         push_bundle,
    output logic            space,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      char_out,
    output logic [1:0]      error_code,
    output logic            last
);

    bundle_t               slot_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic [RES_IDX_W-1:0]  idx_reg, idx_next;

    bundle_t               head;
    result_t               cur;
    logic [RES_CNT_W-1:0]  head_m1;
    logic                  pop;
    logic                  take;

    assign head      = slot_reg[rd_ptr_reg];
    assign cur       = head.res[idx_reg];
    assign head_m1   = head.count - RES_CNT_W'(1);
    assign out_valid = (cnt_reg != 2'd0);
    assign space     = (cnt_reg != 2'd2);
    assign take      = out_valid && out_ready;
    assign pop       = take && (idx_reg == head_m1[RES_IDX_W-1:0]);

    assign kind       = cur.kind;
    assign char_out   = cur.ch;
    assign error_code = cur.err;
    assign last       = cur.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
            idx_next    = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + RES_IDX_W'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/source_comment_whitespace_filter.sv -----
// Top level of the C-style comment and whitespace filter.
// Input channel (in_valid/in_ready): one word per cycle while ready, command
//   plus char_in; 0 is a source byte, 1 an end of line, 2 the end of input.
// Output channel (out_valid/out_ready): cleaned words with kind, char_out,
//   error_code and last; last marks the final word caused by one input word.
// An input word waits in the input register until the queue has space; then
//   the lexer turns it into zero to four result words in the same cycle and
//   stores them as one bundle in a two-entry queue, whose head drives the
//   output channel.
// Throughput: one input word per cycle while each word gives at most one
//   result and the receiver is ready; a word with several results holds the
//   queue head until all are taken; the second entry holds one more bundle.
// A word that gives no result leaves no queue entry.
// When the receiver stalls the queue fills and in_ready drops after the
//   input register is full; no word is dropped.
// After an error every input word is taken and gives nothing until reset.
// Reset (rst_n low) empties the queue and returns the lexer to line start.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module source_comment_whitespace_filter
    import scwf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] char_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      char_out,
    output logic [1:0]      error_code,
    output logic            last
);

    logic       in_full_reg;
    logic [1:0] cmd_reg;
    logic [7:0] ch_reg;
    logic       advance;
    logic       q_space;
    bundle_t    bundle;

    assign advance  = in_full_reg && q_space;
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= command;
            ch_reg  <= char_in;
        end
    end

    scwf_lexer u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .cmd    (cmd_reg),
        .ch     (ch_reg),
        .bundle (bundle)
    );

    scwf_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (advance && (bundle.count != '0)),
        .push_bundle (bundle),
        .space       (q_space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .char_out    (char_out),
        .error_code  (error_code),
        .last        (last)
    );

    `ASSERT_IMPLIES(a_ready_when_empty, !in_full_reg, in_ready, "input register empty but not ready")
    `ASSERT_IMPLIES(a_error_is_last, out_valid && kind == KIND_ERROR, last, "error word not last")
    `ASSERT_IMPLIES(a_char_zero, out_valid && kind != KIND_CHAR, char_out == 8'd0, "nonzero char_out")
    `ASSERT_IMPLIES(a_err_code,
        out_valid && (kind == KIND_ERROR) != (error_code != ERR_NONE), 1'b0,
        "error_code and kind disagree")
    `ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid, "output word dropped while stalled")

endmodule

`default_nettype wire
